### sv/bmlsu_pkg.sv
// ----------------------------------------------------------------------------
// bmlsu_pkg - shared types and constants of the byte memory load/store unit
// Status codes, lane count and the per-request control bundle passed from the
// address decoder to the top level.
// ----------------------------------------------------------------------------
package bmlsu_pkg;

    // Default memory size in bytes
    localparam int MEM_BYTES_DEF = 65536;

    // Byte lanes: one bank per byte of the widest access
    localparam int NUM_LANES = 8;
    localparam int LANE_BITS = 3;

    // Request status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_MISALIGN = 2'd2;

    // Request type codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Byte mask value
    localparam logic [7:0] BYTE_MASK = 8'hff;

    // Control bundle of one decoded request
    typedef struct packed {
        logic [1:0] status;  // result status
        logic       is_read; // successful read, data comes from the banks
        logic [2:0] lo;      // lane holding the lowest byte
        logic [1:0] size;    // log2 of byte count
    } t_req_ctl;

    // Byte count from the size code
    function automatic logic [3:0] nbytes(input logic [1:0] size);
        nbytes = 4'(4'd1 << size);
    endfunction

endpackage

### sv/bmlsu_ram.sv
// ----------------------------------------------------------------------------
// bmlsu_ram - generic single-port synchronous RAM
// One access per cycle at one address, which may read and write at once;
// read data registered and held until the next read.
// ----------------------------------------------------------------------------
module bmlsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, register read data on read enable
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bmlsu_decode.sv
// ----------------------------------------------------------------------------
// bmlsu_decode - request check and byte lane mapping
// Checks range and alignment, then maps each byte of the access onto its
// bank: row address, write enable and write byte per lane.
// ----------------------------------------------------------------------------
module bmlsu_decode #(
    parameter int MEM_BYTES = bmlsu_pkg::MEM_BYTES_DEF,
    parameter int DEPTH     = (MEM_BYTES + bmlsu_pkg::NUM_LANES - 1) / bmlsu_pkg::NUM_LANES,
    parameter int RW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_req_type,
    input  logic [1:0]           i_access_size,
    input  logic [63:0]          i_address,
    input  logic [63:0]          i_write_value,
    input  logic                 i_align_check,
    output bmlsu_pkg::t_req_ctl  o_ctl,
    output logic                 o_lane_we    [bmlsu_pkg::NUM_LANES],
    output logic [RW-1:0]        o_lane_row   [bmlsu_pkg::NUM_LANES],
    output logic [7:0]           o_lane_wdata [bmlsu_pkg::NUM_LANES]
);

    localparam int          LW    = RW + bmlsu_pkg::LANE_BITS;
    localparam logic [63:0] MEM64 = 64'(MEM_BYTES);

    logic [3:0]  nb;
    logic [2:0]  amask;
    logic [1:0]  status;
    logic        ok_write;
    logic [2:0]  offs [bmlsu_pkg::NUM_LANES];
    logic [LW-1:0] bsum [bmlsu_pkg::NUM_LANES];

    // Check range first, then alignment
    always_comb begin
        nb    = bmlsu_pkg::nbytes(i_access_size);
        amask = 3'(nb - 4'd1);
        if (i_address > (MEM64 - 64'(nb))) begin
            status = bmlsu_pkg::ST_RANGE;
        end else if (i_align_check && ((i_address[2:0] & amask) != 3'd0)) begin
            status = bmlsu_pkg::ST_MISALIGN;
        end else begin
            status = bmlsu_pkg::ST_OK;
        end
        ok_write      = (status == bmlsu_pkg::ST_OK) && (i_req_type == bmlsu_pkg::REQ_WRITE);
        o_ctl.status  = status;
        o_ctl.is_read = (status == bmlsu_pkg::ST_OK) && (i_req_type == bmlsu_pkg::REQ_READ);
        o_ctl.lo      = i_address[2:0];
        o_ctl.size    = i_access_size;
    end

    // Map each lane to its byte offset within the access and its row
    always_comb begin
        for (int b = 0; b < bmlsu_pkg::NUM_LANES; b++) begin
            offs[b]         = 3'(b) - i_address[2:0];
            bsum[b]         = i_address[LW-1:0] + LW'(offs[b]);
            o_lane_row[b]   = bsum[b][LW-1:bmlsu_pkg::LANE_BITS];
            o_lane_we[b]    = ok_write && ({1'b0, offs[b]} < nb);
            o_lane_wdata[b] = i_write_value[{offs[b], 3'b000} +: 8] & bmlsu_pkg::BYTE_MASK;
        end
    end

endmodule

### sv/byte_memory_load_store_unit.sv
// ----------------------------------------------------------------------------
// byte_memory_load_store_unit - little-endian byte-addressed load/store unit
// Serves one 1/2/4/8-byte read or write per request from eight byte-lane
// banks, so any access, aligned or not, touches each bank at most once.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  -------   ---  -----------------------------  --------------------------------
//  request   in   i_s_tvalid / o_s_tready        tdata: address, write_value
//                                                tuser: req_type, access_size
//  result    out  o_m_tvalid / i_m_tready        tdata: read_value; tuser: status
//  config    in   i_cfg_valid / o_cfg_ready      i_cfg_data: align_check
//
//  One request per cycle while o_s_tready is high; each request passes the bank
//  read stage (banks read at the accepting edge) and then the result register,
//  from which it is offered on the result channel.
//  Every bank takes one access per cycle, so a read right after a write sees
//  the written bytes without forwarding.
//  A stalled result holds; one further request waits in the bank read stage,
//  after which o_s_tready drops until the result register drains.
//  Reset clears control state and align_check only; memory contents are
//  undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
module byte_memory_load_store_unit #(
    parameter int MEM_BYTES = bmlsu_pkg::MEM_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request: tdata = address[63:0], write_value[127:64]
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [127:0]  i_s_tdata,
    // request: tuser = req_type[0], access_size[2:1]
    input  logic [2:0]    i_s_tuser,
    // result: tdata = read_value[63:0]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [63:0]   o_m_tdata,
    // result: tuser = status[1:0]
    output logic [1:0]    o_m_tuser,
    // configuration: align_check
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    localparam int NL    = bmlsu_pkg::NUM_LANES;
    localparam int DEPTH = (MEM_BYTES + NL - 1) / NL;
    localparam int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bmlsu_pkg::t_req_ctl ctl;
    logic                lane_we    [NL];
    logic [RW-1:0]       lane_row   [NL];
    logic [7:0]          lane_wdata [NL];
    logic [7:0]          lane_rdata [NL];

    logic                r_align;
    logic                r_s1_valid;
    bmlsu_pkg::t_req_ctl r_s1_ctl;
    logic                r_out_valid;
    logic [63:0]         r_out_data;
    logic [1:0]          r_out_status;
    logic [63:0]         n_out_data;

    logic                in_acc;
    logic                s1_adv;
    logic [3:0]          s1_nb;
    logic [2:0]          s1_lane;

    // Decode request into per-lane bank accesses
    bmlsu_decode #(
        .MEM_BYTES (MEM_BYTES),
        .DEPTH     (DEPTH),
        .RW        (RW)
    ) u_decode (
        .i_req_type    (i_s_tuser[0]),
        .i_access_size (i_s_tuser[2:1]),
        .i_address     (i_s_tdata[63:0]),
        .i_write_value (i_s_tdata[127:64]),
        .i_align_check (r_align),
        .o_ctl         (ctl),
        .o_lane_we     (lane_we),
        .o_lane_row    (lane_row),
        .o_lane_wdata  (lane_wdata)
    );

    // One bank per byte lane
    for (genvar g = 0; g < NL; g++) begin : g_lane
        bmlsu_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH),
            .AW    (RW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (in_acc && lane_we[g]),
            .i_re    (in_acc),
            .i_addr  (lane_row[g]),
            .i_wdata (lane_wdata[g]),
            .o_rdata (lane_rdata[g])
        );
    end

    // Handshake: advance the read stage when the result register frees up
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_s1_valid || s1_adv;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Assemble read data little-endian from the lanes, zero unused bytes
    always_comb begin
        s1_nb      = bmlsu_pkg::nbytes(r_s1_ctl.size);
        n_out_data = '0;
        s1_lane    = '0;
        for (int i = 0; i < NL; i++) begin
            s1_lane = r_s1_ctl.lo + 3'(i);
            if (r_s1_ctl.is_read && (4'(i) < s1_nb)) begin
                n_out_data[i*8 +: 8] = lane_rdata[s1_lane];
            end
        end
    end

    // Hold configuration and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_align <= i_cfg_data;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture request control and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctl <= ctl;
        end
        if (s1_adv) begin
            r_out_data   <= n_out_data;
            r_out_status <= r_s1_ctl.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    // A failed request carries zero read data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != bmlsu_pkg::ST_OK)) |-> (r_out_data == 64'd0))
        else $error("error result with non-zero read data");

    // Status code is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_status == bmlsu_pkg::ST_OK) ||
                         (r_out_status == bmlsu_pkg::ST_RANGE) ||
                         (r_out_status == bmlsu_pkg::ST_MISALIGN)))
        else $error("undefined status code");

    // A rejected request never writes a bank
    a_no_bad_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (ctl.status != bmlsu_pkg::ST_OK)) |-> ($countones({lane_we[0],
            lane_we[1], lane_we[2], lane_we[3], lane_we[4], lane_we[5], lane_we[6],
            lane_we[7]}) == 0))
        else $error("bank written by rejected request");

    // A stuck read stage keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_ctl)))
        else $error("read stage lost a request while stalled");

    // The read stage never takes a request while it cannot pass its own on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("request accepted into a full pipeline");

endmodule
